### hdl/stx_length_frame_receiver_core_assert.svh
// Assertion macros used by the length frame receiver parser.
`ifndef STX_LENGTH_FRAME_RECEIVER_CORE_ASSERT_SVH
`define STX_LENGTH_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STX_LFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STX_LFR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/stx_lfr_pkg.sv
// Package with types and constants of the length frame receiver.
package stx_lfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int EV_W   = 2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'd2;
    localparam logic [LEN_W-1:0]  MAX_BODY_LEN_RST = 16'd249;

    // Result event codes.
    localparam logic [EV_W-1:0] EV_BODY     = 2'd0;
    localparam logic [EV_W-1:0] EV_GOOD_END = 2'd1;
    localparam logic [EV_W-1:0] EV_BAD_SUM  = 2'd2;
    localparam logic [EV_W-1:0] EV_OVERLEN  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_START_BYTE   = 1'b0;
    localparam logic CFG_MAX_BODY_LEN = 1'b1;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_BODY
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [LEN_W-1:0]  max_body_len;
    } t_cfg;

    typedef struct packed {
        logic [EV_W-1:0]   ev_res;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  offset;
        logic              is_type;
    } t_result;

endpackage

### hdl/stx_length_frame_receiver_core.sv
// A result is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle unless stalled, set by the single result register stage.
// A byte is taken whenever the result register is empty or is being emptied in that cycle.
// Reset is synchronous and active low; it clears the frame state, restores the default
// start byte and length limit, and empties the result register. There is no clearing pass.
module stx_length_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,

    // Received byte channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,

    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_data,
    output logic [15:0] o_offset,
    output logic        o_is_type
);

    // A transfer on the input side happens whenever a byte is offered and the
    // result register can take whatever that byte produces. The register can
    // always take a result unless it holds one that the output side stalls, so
    // the input stall is just the stalled-and-full condition of that register.
    stx_lfr_pkg::t_cfg    cfg;
    stx_lfr_pkg::t_result res_next;
    stx_lfr_pkg::t_result res_out;
    logic                 res_next_valid;
    logic                 in_take;
    logic                 out_busy;

    assign in_take    = i_in_valid && !out_busy;
    assign o_in_stall = out_busy;

    stx_lfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // The parser holds the frame state: which header byte comes next, the
    // captured length, the body offset and the running checksum. It decides
    // the result of the byte being transferred in the same cycle.
    stx_lfr_deframe u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (in_take),
        .i_byte      (i_rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_next_valid),
        .o_res       (res_next)
    );

    // The result register separates the two channels so a finished result can
    // wait while the next byte is already being parsed.
    stx_lfr_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_next_valid),
        .i_res   (res_next),
        .i_take  (in_take),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_busy  (out_busy),
        .o_res   (res_out)
    );

    assign o_event_res = res_out.ev_res;
    assign o_data      = res_out.data;
    assign o_offset    = res_out.offset;
    assign o_is_type   = res_out.is_type;

endmodule

### hdl/stx_lfr_cfg.sv
// Configuration registers of the length frame receiver.
module stx_lfr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [stx_lfr_pkg::LEN_W-1:0]  i_cfg_wdata,
    output stx_lfr_pkg::t_cfg              o_cfg
);

    logic [stx_lfr_pkg::BYTE_W-1:0] r_start_byte;
    logic [stx_lfr_pkg::LEN_W-1:0]  r_max_body_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= stx_lfr_pkg::START_BYTE_RST;
            r_max_body_len <= stx_lfr_pkg::MAX_BODY_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stx_lfr_pkg::CFG_START_BYTE: begin
                    r_start_byte <= i_cfg_wdata[stx_lfr_pkg::BYTE_W-1:0];
                end
                stx_lfr_pkg::CFG_MAX_BODY_LEN: begin
                    r_max_body_len <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.start_byte   = r_start_byte;
    assign o_cfg.max_body_len = r_max_body_len;

endmodule

### hdl/stx_lfr_deframe.sv
// Frame parser: start hunt, length capture, body count and checksum.
`include "stx_length_frame_receiver_core_assert.svh"

module stx_lfr_deframe (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_take,
    input  logic [stx_lfr_pkg::BYTE_W-1:0]  i_byte,
    input  stx_lfr_pkg::t_cfg               i_cfg,
    output logic                            o_res_valid,
    output stx_lfr_pkg::t_result            o_res
);

    stx_lfr_pkg::t_state            r_state, n_state;
    logic [stx_lfr_pkg::LEN_W-1:0]  r_len, n_len;
    logic [stx_lfr_pkg::LEN_W-1:0]  r_off, n_off;
    logic [stx_lfr_pkg::BYTE_W-1:0] r_sum, n_sum;

    logic [stx_lfr_pkg::BYTE_W-1:0] sum_add;
    logic [stx_lfr_pkg::LEN_W-1:0]  full_len;
    logic                           overlen;
    logic                           body_more;

    assign sum_add   = r_sum + i_byte;
    assign full_len  = {i_byte, r_len[stx_lfr_pkg::BYTE_W-1:0]};
    assign overlen   = full_len > i_cfg.max_body_len;
    assign body_more = r_off < r_len;

    // Next state and frame bookkeeping.
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_off   = r_off;
        n_sum   = r_sum;
        if (i_take) begin
            case (r_state)
                stx_lfr_pkg::ST_HUNT: begin
                    if (i_byte == i_cfg.start_byte) begin
                        n_state = stx_lfr_pkg::ST_LEN_LO;
                        n_sum   = i_byte;
                        n_len   = '0;
                        n_off   = '0;
                    end
                end
                stx_lfr_pkg::ST_LEN_LO: begin
                    n_state = stx_lfr_pkg::ST_LEN_HI;
                    n_sum   = sum_add;
                    n_len   = {{(stx_lfr_pkg::LEN_W-stx_lfr_pkg::BYTE_W){1'b0}}, i_byte};
                end
                stx_lfr_pkg::ST_LEN_HI: begin
                    if (overlen) begin
                        n_state = stx_lfr_pkg::ST_HUNT;
                        n_sum   = '0;
                        n_len   = '0;
                    end else begin
                        n_state = stx_lfr_pkg::ST_BODY;
                        n_sum   = sum_add;
                        n_len   = full_len;
                        n_off   = '0;
                    end
                end
                stx_lfr_pkg::ST_BODY: begin
                    if (body_more) begin
                        n_sum = sum_add;
                        n_off = r_off + 1'b1;
                    end else begin
                        n_state = stx_lfr_pkg::ST_HUNT;
                        n_sum   = '0;
                        n_len   = '0;
                        n_off   = '0;
                    end
                end
                default: begin
                    n_state = stx_lfr_pkg::ST_HUNT;
                end
            endcase
        end
    end

    // Result produced by the byte being taken.
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_take) begin
            case (r_state)
                stx_lfr_pkg::ST_LEN_HI: begin
                    if (overlen) begin
                        o_res_valid  = 1'b1;
                        o_res.ev_res = stx_lfr_pkg::EV_OVERLEN;
                        o_res.offset = full_len;
                    end
                end
                stx_lfr_pkg::ST_BODY: begin
                    o_res_valid = 1'b1;
                    if (body_more) begin
                        o_res.ev_res  = stx_lfr_pkg::EV_BODY;
                        o_res.data    = i_byte;
                        o_res.offset  = r_off;
                        o_res.is_type = (r_off == '0);
                    end else begin
                        o_res.ev_res = (sum_add == '0) ? stx_lfr_pkg::EV_GOOD_END
                                                       : stx_lfr_pkg::EV_BAD_SUM;
                        o_res.offset = r_len;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stx_lfr_pkg::ST_HUNT;
            r_len   <= '0;
            r_off   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_off   <= n_off;
            r_sum   <= n_sum;
        end
    end

    `STX_LFR_ASSERT_IMP(a_hunt_silent, i_clk, i_rst_n, (r_state == stx_lfr_pkg::ST_HUNT) || (r_state == stx_lfr_pkg::ST_LEN_LO), !o_res_valid, "result produced while hunting or reading low length byte")
    `STX_LFR_ASSERT_IMP(a_body_in_range, i_clk, i_rst_n, o_res_valid && (o_res.ev_res == stx_lfr_pkg::EV_BODY), o_res.offset < r_len, "body offset beyond frame length")
    `STX_LFR_ASSERT_IMP(a_type_first, i_clk, i_rst_n, o_res_valid && o_res.is_type, (o_res.offset == '0) && (o_res.ev_res == stx_lfr_pkg::EV_BODY), "type flag away from first body byte")
    `STX_LFR_ASSERT_NXT(a_end_hunts, i_clk, i_rst_n, i_take && (r_state == stx_lfr_pkg::ST_BODY) && !body_more, (r_state == stx_lfr_pkg::ST_HUNT) && (r_sum == '0), "no return to hunt after check byte")

endmodule

### hdl/stx_lfr_outreg.sv
// Result register between the parser and the output channel.
module stx_lfr_outreg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  stx_lfr_pkg::t_result  i_res,
    input  logic                  i_take,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic                  o_busy,
    output stx_lfr_pkg::t_result  o_res
);

    logic                 r_valid;
    stx_lfr_pkg::t_result r_res;
    logic                 drain;

    assign drain  = r_valid && !i_stall;
    assign o_busy = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take && i_load) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### tb/sv/stx_length_frame_receiver_core_tb.sv
// Self-checking testbench of the length frame receiver core: directed table and random frames.
module stx_length_frame_receiver_core_tb;

    // How a stimulus row is checked: against the predictor, as a byte that must give no
    // result, or against the result typed into the row.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_RESULT
    } t_row_mode;

    typedef struct {
        logic [7:0]           rx;
        t_row_mode            mode;
        stx_lfr_pkg::t_result res;
    } t_rx_item;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = stx_lfr_pkg::CFG_START_BYTE;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_event_res;
    logic [7:0]  o_data;
    logic [15:0] o_offset;
    logic        o_is_type;

    stx_length_frame_receiver_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_event_res (o_event_res),
        .o_data      (o_data),
        .o_offset    (o_offset),
        .o_is_type   (o_is_type)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bytes offered to the block, in order, waiting for their input transfer.
    t_rx_item             offered_bytes [$];
    // Frame events that the block still owes on its result channel.
    stx_lfr_pkg::t_result pending_events [$];
    // Byte stream of the current random phase.
    logic [7:0]           phase_bytes [$];
    int                   mismatches = 0;

    // Idle and stall rates in percent, and a requested hold-off of the result side.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    // Own copy of the configuration and of the frame state.
    logic [7:0]  cur_start   = stx_lfr_pkg::START_BYTE_RST;
    logic [15:0] cur_max_len = stx_lfr_pkg::MAX_BODY_LEN_RST;
    logic [16:0] frame_bytes_seen = '0;
    logic [15:0] frame_len = '0;
    logic [7:0]  frame_sum = '0;

    // Advances the frame state by one received byte. Returns 1 when the byte completes
    // a result, which is then left in ev.
    function automatic bit deframe_byte(input logic [7:0] b, output stx_lfr_pkg::t_result ev);
        logic [16:0] pos;
        ev = '0;
        // While hunting, anything but the start byte is dropped.
        if (frame_bytes_seen == 0) begin
            if (b == cur_start) begin
                frame_sum = b;
                frame_len = '0;
                frame_bytes_seen = 17'd1;
            end
            return 1'b0;
        end
        frame_sum = frame_sum + b;
        if (frame_bytes_seen == 1) begin
            frame_len = {8'h00, b};
            frame_bytes_seen = 17'd2;
            return 1'b0;
        end
        if (frame_bytes_seen == 2) begin
            frame_len[15:8] = b;
            if (frame_len > cur_max_len) begin
                ev.ev_res = stx_lfr_pkg::EV_OVERLEN;
                ev.offset = frame_len;
                frame_bytes_seen = '0;
                frame_len = '0;
                frame_sum = '0;
                return 1'b1;
            end
            frame_bytes_seen = 17'd3;
            return 1'b0;
        end
        // Past the header: body bytes until the length is used up, then the check byte.
        pos = frame_bytes_seen - 17'd3;
        if (pos < {1'b0, frame_len}) begin
            frame_bytes_seen = frame_bytes_seen + 17'd1;
            ev.ev_res  = stx_lfr_pkg::EV_BODY;
            ev.data    = b;
            ev.offset  = pos[15:0];
            ev.is_type = (pos == 0);
            return 1'b1;
        end
        ev.ev_res = (frame_sum == 0) ? stx_lfr_pkg::EV_GOOD_END : stx_lfr_pkg::EV_BAD_SUM;
        ev.offset = frame_len;
        frame_bytes_seen = '0;
        frame_len = '0;
        frame_sum = '0;
        return 1'b1;
    endfunction

    function automatic t_rx_item row(input logic [7:0] b, input t_row_mode mode,
                                     input logic [1:0] ev, input logic [7:0] d,
                                     input logic [15:0] off, input logic ty);
        t_rx_item it;
        it.rx   = b;
        it.mode = mode;
        it.res  = {ev, d, off, ty};
        return it;
    endfunction

    // All transfers are sampled at the rising edge, before any of this edge's updates land,
    // so the predictor sees exactly what the block sees.
    always @(posedge i_clk) begin : check_transfers
        t_rx_item             it;
        stx_lfr_pkg::t_result pred;
        stx_lfr_pkg::t_result want;
        stx_lfr_pkg::t_result got;
        bit                   has;
        if (!i_rst_n) begin
            cur_start = stx_lfr_pkg::START_BYTE_RST;
            cur_max_len = stx_lfr_pkg::MAX_BODY_LEN_RST;
            frame_bytes_seen = '0;
            frame_len = '0;
            frame_sum = '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                it = offered_bytes.pop_front();
                has = deframe_byte(it.rx, pred);
                case (it.mode)
                    ROW_PREDICT: begin
                        if (has)
                            pending_events.push_back(pred);
                    end
                    ROW_RESULT: pending_events.push_back(it.res);
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_event_res, o_data, o_offset, o_is_type};
                if (pending_events.size() == 0) begin
                    $error({"result transfer with nothing expected: ",
                            "event_res %0d data %0d offset %0d is_type %0d"},
                           got.ev_res, got.data, got.offset, got.is_type);
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    if (got.ev_res !== want.ev_res) begin
                        $error("event_res: expected %0d, actual %0d", want.ev_res, got.ev_res);
                        mismatches++;
                    end
                    if (got.data !== want.data) begin
                        $error("data: expected %0d, actual %0d", want.data, got.data);
                        mismatches++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("offset: expected %0d, actual %0d", want.offset, got.offset);
                        mismatches++;
                    end
                    if (got.is_type !== want.is_type) begin
                        $error("is_type: expected %0d, actual %0d", want.is_type, got.is_type);
                        mismatches++;
                    end
                end
            end
            // A register write counts for the bytes after it, so it is applied last.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    stx_lfr_pkg::CFG_START_BYTE:   cur_start = i_cfg_wdata[7:0];
                    stx_lfr_pkg::CFG_MAX_BODY_LEN: cur_max_len = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Result side. A requested hold-off is counted down here, cycle by cycle; otherwise the
    // stall is drawn at the current rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req != 0) begin
            hold_left = hold_req - 1;
            hold_req = 0;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offers one byte, after a random gap, and returns at the edge of its input transfer.
    // Valid stays high from one byte to the next when no gap is drawn.
    task automatic send_item(input t_rx_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        offered_bytes.push_back(it);
        i_in_valid <= 1'b1;
        i_rx_byte  <= it.rx;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Waits until every expected event has come out, then lets the result stage settle so
    // that a byte that gives no result is also through before any register write.
    task automatic wait_idle();
        int n;
        n = 0;
        @(posedge i_clk);
        while (pending_events.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        if (pending_events.size() != 0) begin
            $error("%0d expected results never arrived", pending_events.size());
            mismatches++;
            pending_events.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back edges; the write enable stays high in between.
    task automatic set_config(input logic [7:0] sb, input logic [15:0] max_len);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= stx_lfr_pkg::CFG_START_BYTE;
        i_cfg_wdata <= {8'h00, sb};
        @(posedge i_clk);
        i_cfg_idx   <= stx_lfr_pkg::CFG_MAX_BODY_LEN;
        i_cfg_wdata <= max_len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Appends one frame to the phase stream: now and then a little noise first, mostly short
    // well-formed frames with a correct check byte, some with a wrong one, some over the
    // length limit and a few cut short so that the next bytes land inside them.
    task automatic add_frame(input logic [7:0] sb, input logic [15:0] max_len);
        int         len;
        int         lim;
        int         cut;
        logic [7:0] sum;
        logic [7:0] frame [$];
        lim = int'(max_len);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) phase_bytes.push_back(8'($urandom_range(255)));
        if (lim < 65535 && $urandom_range(9) == 0)
            len = $urandom_range(65535, lim + 1);
        else if ($urandom_range(19) == 0)
            len = $urandom_range((lim < 64) ? lim : 64, 0);
        else
            len = $urandom_range((lim < 12) ? lim : 12, 0);
        frame.push_back(sb);
        frame.push_back(len[7:0]);
        frame.push_back(len[15:8]);
        if (len <= lim) begin
            repeat (len) frame.push_back(8'($urandom_range(255)));
            sum = '0;
            foreach (frame[i])
                sum = sum + frame[i];
            if ($urandom_range(99) < 85)
                frame.push_back(8'h00 - sum);
            else
                frame.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(19) == 0) begin
            cut = $urandom_range(frame.size() - 1, 1);
            frame = frame[0:cut-1];
        end
        foreach (frame[i])
            phase_bytes.push_back(frame[i]);
    endtask

    // One random phase: settle, write both registers, set the idle rates and send a stream
    // of frames. A nonzero hold makes the result side hold off while bytes keep coming.
    task automatic run_phase(input logic [7:0] sb, input logic [15:0] max_len,
                             input int idle_p, input int stall_p, input int hold,
                             input int count);
        wait_idle();
        set_config(sb, max_len);
        send_idle_pct = idle_p;
        stall_pct = stall_p;
        phase_bytes.delete();
        while (phase_bytes.size() < count)
            add_frame(sb, max_len);
        if (hold != 0)
            hold_req = hold;
        foreach (phase_bytes[i])
            send_item(row(phase_bytes[i], ROW_PREDICT, stx_lfr_pkg::EV_BODY,
                          8'h00, 16'd0, 1'b0));
        i_in_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_rx_item directed_rows [$];

        // Directed table, run with the reset settings: start byte 2, length limit 249.
        // Bytes that are not the start byte are dropped while hunting.
        directed_rows.push_back(row(8'h00, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'hFF, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        // Zero length with a correct check byte gives a good end at once.
        directed_rows.push_back(row(8'h02, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h00, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h00, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'hFE, ROW_RESULT, stx_lfr_pkg::EV_GOOD_END,
                                    8'h00, 16'd0, 1'b0));
        // Zero length with a wrong check byte.
        directed_rows.push_back(row(8'h02, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h00, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h00, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h00, ROW_RESULT, stx_lfr_pkg::EV_BAD_SUM,
                                    8'h00, 16'd0, 1'b0));
        // One above the limit, then the largest length of all.
        directed_rows.push_back(row(8'h02, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'hFA, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h00, ROW_RESULT, stx_lfr_pkg::EV_OVERLEN,
                                    8'h00, 16'd250, 1'b0));
        directed_rows.push_back(row(8'h02, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'hFF, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'hFF, ROW_RESULT, stx_lfr_pkg::EV_OVERLEN,
                                    8'h00, 16'hFFFF, 1'b0));
        // Two body bytes at the data extremes; the first one is the message type.
        directed_rows.push_back(row(8'h02, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h02, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h00, ROW_NONE, stx_lfr_pkg::EV_BODY, 8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'hFF, ROW_RESULT, stx_lfr_pkg::EV_BODY,
                                    8'hFF, 16'd0, 1'b1));
        directed_rows.push_back(row(8'h00, ROW_RESULT, stx_lfr_pkg::EV_BODY,
                                    8'h00, 16'd1, 1'b0));
        directed_rows.push_back(row(8'hFD, ROW_RESULT, stx_lfr_pkg::EV_GOOD_END,
                                    8'h00, 16'd2, 1'b0));
        // A length right at the limit is taken. The frame stays open into the first
        // random phase, so its register writes land in the middle of a frame.
        directed_rows.push_back(row(8'h02, ROW_PREDICT, stx_lfr_pkg::EV_BODY,
                                    8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'hF9, ROW_PREDICT, stx_lfr_pkg::EV_BODY,
                                    8'h00, 16'd0, 1'b0));
        directed_rows.push_back(row(8'h00, ROW_PREDICT, stx_lfr_pkg::EV_BODY,
                                    8'h00, 16'd0, 1'b0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        i_in_valid <= 1'b0;

        // Random phases: register extremes first, then random and fixed settings under sender gaps,
        // result stalls or both, and one phase with the reset settings where the result side holds off
        // for a long stretch while the sender keeps offering.
        run_phase(8'h00, 16'd1, 0, 0, 0, 100);
        run_phase(8'hFF, 16'hFFFF, 50, 0, 0, 100);
        run_phase(8'($urandom_range(255)), 16'($urandom_range(40, 1)), 0, 50, 0, 100);
        run_phase(8'h7E, 16'd16, 8, 8, 0, 100);
        run_phase(stx_lfr_pkg::START_BYTE_RST, stx_lfr_pkg::MAX_BODY_LEN_RST, 0, 0, 60, 100);
        run_phase(8'($urandom_range(255)), 16'($urandom_range(65535, 1)), 8, 8, 0, 100);

        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guards against a hung handshake; far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
